>>> hw/rtl/secal_pkg.sv
// Types, constants and stage functions of the synced epoch to calendar time converter.
`default_nettype none

package secal_pkg;

    localparam int IN_W       = 32;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_W      = 44;
    localparam int CFG_IDX_W  = 2;
    localparam int X_W        = 45;
    localparam int REM_W      = 10;
    localparam int DR_W       = 20;
    localparam int SPAN_MAX   = 1024;
    localparam int SHIFT_MAXK = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_EPOCH_MS = 2'd0,
        CFG_SYNC_TICK_MS  = 2'd1,
        CFG_TZ_OFFSET_MIN = 2'd2,
        CFG_TIME_SYNCED   = 2'd3
    } t_cfg_idx;

    localparam int MS_STEP  = 5;
    localparam int MS_N     = X_W / MS_STEP;
    localparam int SEC_STEP = 6;
    localparam int S1_N     = 36 / SEC_STEP;
    localparam int S2_N     = 30 / SEC_STEP;
    localparam int HR_N     = 24 / SEC_STEP;

    localparam int ST_CAP   = 0;
    localparam int ST_DIFF  = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_MS0   = 3;
    localparam int ST_LOCAL = ST_MS0 + MS_N;
    localparam int ST_S0    = ST_LOCAL + 1;
    localparam int ST_SEC   = ST_S0 + S1_N;
    localparam int ST_M0    = ST_SEC + 1;
    localparam int ST_MIN   = ST_M0 + S2_N;
    localparam int ST_H0    = ST_MIN + 1;
    localparam int ST_DAY   = ST_H0 + HR_N;
    localparam int ST_N400  = ST_DAY + 1;
    localparam int ST_N100  = ST_N400 + 1;
    localparam int ST_N4    = ST_N100 + 1;
    localparam int ST_N1    = ST_N4 + 1;
    localparam int ST_OUT   = ST_N1 + 1;
    localparam int NST      = ST_OUT + 1;

    localparam logic [DR_W-1:0] DAYS_1601_TO_1970 = 20'd134774;
    localparam logic [11:0]     BASE_YEAR         = 12'd1970;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic              wall;
        logic              oor;
        logic [X_W-1:0]    x;
        logic [REM_W-1:0]  r;
        logic [5:0]        secs;
        logic [5:0]        mins;
        logic [10:0]       uphr;
        logic [4:0]        hr;
        logic [DR_W-1:0]   dr;
        logic [1:0]        n400;
        logic [1:0]        n100;
        logic [4:0]        n4;
        logic              leap;
        logic [11:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [10:0]       hours;
    } t_pipe;

    typedef struct packed {
        logic [4:0]      q;
        logic [DR_W-1:0] r;
    } t_qr;

    function automatic logic is_leap(input int yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic logic [DR_W-1:0] day_limit(input int span);
        int unsigned total;
        total = 0;
        for (int y = 0; y < SPAN_MAX; y++) begin
            if (y < span) begin
                total = total + (is_leap(1970 + y) ? 366 : 365);
            end
        end
        return DR_W'(total);
    endfunction

    // Restoring division steps; the dividend is left-aligned in x and the
    // quotient bits fill x from the bottom.
    function automatic t_pipe div_shift(input t_pipe p, input logic [REM_W-1:0] d,
                                        input int n);
        t_pipe             o;
        logic [REM_W:0]    acc;
        o = p;
        for (int k = 0; k < SHIFT_MAXK; k++) begin
            if (k < n) begin
                acc  = {o.r, o.x[X_W-1]};
                o.x  = {o.x[X_W-2:0], 1'b0};
                if (acc >= {1'b0, d}) begin
                    acc    = acc - {1'b0, d};
                    o.x[0] = 1'b1;
                end
                o.r = acc[REM_W-1:0];
            end
        end
        return o;
    endfunction

    // Short quotient by compare and subtract of shifted divisors.
    function automatic t_qr div_small(input logic [DR_W-1:0] r, input logic [17:0] d,
                                      input int q_bits);
        t_qr          o;
        logic [24:0]  dk;
        o.q = '0;
        o.r = r;
        for (int k = 4; k >= 0; k--) begin
            if (k < q_bits) begin
                dk = {7'b0, d} << k;
                if ({5'b0, o.r} >= dk) begin
                    o.r    = o.r - dk[DR_W-1:0];
                    o.q[k] = 1'b1;
                end
            end
        end
        return o;
    endfunction

    function automatic t_pipe st_capture(input logic [IN_W-1:0] now, input logic synced);
        t_pipe o;
        o      = '0;
        o.x    = {13'b0, now};
        o.wall = synced;
        return o;
    endfunction

    function automatic t_pipe st_diff(input t_pipe p, input logic [IN_W-1:0] tick);
        t_pipe o;
        o = p;
        if (p.wall) begin
            o.x[IN_W-1:0] = p.x[IN_W-1:0] - tick;
        end
        return o;
    endfunction

    function automatic t_pipe st_sum(input t_pipe p, input logic [CFG_W-1:0] epoch);
        t_pipe o;
        o   = p;
        o.r = '0;
        if (p.wall) begin
            o.x = {1'b0, epoch} + {13'b0, p.x[IN_W-1:0]};
        end
        return o;
    endfunction

    function automatic t_pipe st_local(input t_pipe p, input logic [10:0] tz);
        t_pipe              o;
        logic signed [37:0] tzs;
        logic signed [37:0] tz60;
        logic signed [37:0] loc;
        o    = p;
        tzs  = 38'($signed(tz));
        tz60 = (tzs <<< 6) - (tzs <<< 2);
        loc  = $signed({2'b0, p.x[35:0]}) + (p.wall ? tz60 : 38'sd0);
        o.oor = p.wall & loc[37];
        o.x   = loc[37] ? '0 : {loc[35:0], 9'b0};
        o.r   = '0;
        return o;
    endfunction

    function automatic t_pipe st_sec(input t_pipe p);
        t_pipe o;
        o      = p;
        o.secs = p.r[5:0];
        o.x    = {p.x[29:0], 15'b0};
        o.r    = '0;
        return o;
    endfunction

    function automatic t_pipe st_min(input t_pipe p);
        t_pipe o;
        o      = p;
        o.mins = p.r[5:0];
        o.uphr = p.x[10:0];
        o.x    = {p.x[23:0], 21'b0};
        o.r    = '0;
        return o;
    endfunction

    function automatic t_pipe st_day(input t_pipe p, input logic [DR_W-1:0] limit);
        t_pipe o;
        o    = p;
        o.hr = p.r[4:0];
        if (p.wall && (p.x[DR_W-1:0] >= limit)) begin
            o.oor = 1'b1;
        end
        o.dr = p.x[DR_W-1:0] + DAYS_1601_TO_1970;
        return o;
    endfunction

    function automatic t_pipe st_n400(input t_pipe p);
        t_pipe o;
        t_qr   qr;
        o      = p;
        qr     = div_small(p.dr, 18'd146097, 2);
        o.n400 = qr.q[1:0];
        o.dr   = qr.r;
        return o;
    endfunction

    // Two quotient bits cap the count at three, which keeps the last day of a
    // four-century cycle in the final century.
    function automatic t_pipe st_n100(input t_pipe p);
        t_pipe o;
        t_qr   qr;
        o      = p;
        qr     = div_small(p.dr, 18'd36524, 2);
        o.n100 = qr.q[1:0];
        o.dr   = qr.r;
        return o;
    endfunction

    function automatic t_pipe st_n4(input t_pipe p);
        t_pipe o;
        t_qr   qr;
        o    = p;
        qr   = div_small(p.dr, 18'd1461, 5);
        o.n4 = qr.q;
        o.dr = qr.r;
        return o;
    endfunction

    function automatic t_pipe st_n1(input t_pipe p);
        t_pipe      o;
        t_qr        qr;
        logic [1:0] n1;
        o      = p;
        qr     = div_small(p.dr, 18'd365, 2);
        n1     = qr.q[1:0];
        o.dr   = qr.r;
        o.year = 12'd1601 + 12'(p.n400) * 12'd400 + 12'(p.n100) * 12'd100
               + {5'b0, p.n4, 2'b0} + {10'b0, n1};
        o.leap = (n1 == 2'd3) && ((p.n4 != 5'd24) || (p.n100 == 2'd3));
        return o;
    endfunction

    function automatic t_pipe st_out(input t_pipe p);
        t_pipe      o;
        logic [8:0] doy;
        logic [8:0] th;
        logic [8:0] th_sel;
        logic [3:0] m_idx;
        o      = p;
        doy    = p.dr[8:0];
        m_idx  = '0;
        th_sel = '0;
        for (int k = 1; k < 12; k++) begin
            th = MONTH_START[k] + {8'b0, (k >= 2) && p.leap};
            if (doy >= th) begin
                m_idx  = 4'(k);
                th_sel = th;
            end
        end
        if (!p.wall) begin
            o.year  = BASE_YEAR;
            o.month = 4'd1;
            o.day   = 5'd1;
            o.hours = p.uphr;
            o.oor   = 1'b0;
        end else if (p.oor) begin
            o.year  = BASE_YEAR;
            o.month = 4'd1;
            o.day   = 5'd1;
            o.hours = '0;
            o.mins  = '0;
            o.secs  = '0;
        end else begin
            o.month = m_idx + 4'd1;
            o.day   = 5'(doy - th_sel) + 5'd1;
            o.hours = {6'b0, p.hr};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/synced_epoch_to_calendar_time.sv
// Top level of the synced epoch to calendar time converter pipeline.
//
// Channel      Direction  Content
// s_axis       in         tdata[31:0] now_tick_ms
// m_axis       out        tdata year to out_of_range as on the port, tuser is_wall_clock
// cfg          in         write enable, register index, write data
//
// One request enters per cycle while the output is not stalled; each result passes through every stage in order.
// The pipeline consists of three front stages, the bit-serial division chains by 1000, 60, 60
// and 24 that advance five (by 1000) or six quotient bits per stage with one stage after each chain,
// and five calendar stages.
// Reset is synchronous and active low; it clears the valid bits and the configuration registers, not the pipeline data.
// A stalled output holds only the stages that are full; empty stages keep filling.
`default_nettype none

module synced_epoch_to_calendar_time #(
    parameter int YEAR_SPAN = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [secal_pkg::IN_W-1:0]          i_s_axis_tdata,  // now_tick_ms
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // cal_year, cal_month, cal_day, hours, minutes, seconds, out_of_range, zero fill
    output logic [secal_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    output logic                                     o_m_axis_tuser,  // is_wall_clock
    input  wire logic                                i_cfg_we,
    input  wire secal_pkg::t_cfg_idx                 i_cfg_idx,
    input  wire logic [secal_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import secal_pkg::*;

    localparam logic [DR_W-1:0] DAY_LIMIT = day_limit(YEAR_SPAN);

    logic [CFG_W-1:0] r_sync_epoch;
    logic [IN_W-1:0]  r_sync_tick;
    logic [10:0]      r_tz_offset;
    logic             r_time_synced;

    t_pipe            r_pipe [NST];
    t_pipe            n_pipe [NST];
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   w_adv;
    t_pipe            w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_epoch  <= '0;
            r_sync_tick   <= '0;
            r_tz_offset   <= '0;
            r_time_synced <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_EPOCH_MS: begin
                    r_sync_epoch <= i_cfg_wdata;
                end
                CFG_SYNC_TICK_MS: begin
                    r_sync_tick <= i_cfg_wdata[IN_W-1:0];
                end
                CFG_TZ_OFFSET_MIN: begin
                    r_tz_offset <= i_cfg_wdata[10:0];
                end
                CFG_TIME_SYNCED: begin
                    r_time_synced <= i_cfg_wdata[0];
                end
            endcase
        end
    end

    for (genvar gi = 0; gi < NST; gi++) begin : g_st
        if (gi == NST - 1) begin : g_last_adv
            assign w_adv[gi] = !r_vld[gi] || i_m_axis_tready;
        end else begin : g_mid_adv
            assign w_adv[gi] = !r_vld[gi] || w_adv[gi+1];
        end

        if (gi == ST_CAP) begin : g_cap
            assign n_pipe[gi] = st_capture(i_s_axis_tdata, r_time_synced);
        end else if (gi == ST_DIFF) begin : g_diff
            assign n_pipe[gi] = st_diff(r_pipe[gi-1], r_sync_tick);
        end else if (gi == ST_SUM) begin : g_sum
            assign n_pipe[gi] = st_sum(r_pipe[gi-1], r_sync_epoch);
        end else if (gi < ST_LOCAL) begin : g_ms
            assign n_pipe[gi] = div_shift(r_pipe[gi-1], 10'd1000, MS_STEP);
        end else if (gi == ST_LOCAL) begin : g_local
            assign n_pipe[gi] = st_local(r_pipe[gi-1], r_tz_offset);
        end else if (gi < ST_SEC) begin : g_s1
            assign n_pipe[gi] = div_shift(r_pipe[gi-1], 10'd60, SEC_STEP);
        end else if (gi == ST_SEC) begin : g_sec
            assign n_pipe[gi] = st_sec(r_pipe[gi-1]);
        end else if (gi < ST_MIN) begin : g_s2
            assign n_pipe[gi] = div_shift(r_pipe[gi-1], 10'd60, SEC_STEP);
        end else if (gi == ST_MIN) begin : g_min
            assign n_pipe[gi] = st_min(r_pipe[gi-1]);
        end else if (gi < ST_DAY) begin : g_hr
            assign n_pipe[gi] = div_shift(r_pipe[gi-1], 10'd24, SEC_STEP);
        end else if (gi == ST_DAY) begin : g_day
            assign n_pipe[gi] = st_day(r_pipe[gi-1], DAY_LIMIT);
        end else if (gi == ST_N400) begin : g_n400
            assign n_pipe[gi] = st_n400(r_pipe[gi-1]);
        end else if (gi == ST_N100) begin : g_n100
            assign n_pipe[gi] = st_n100(r_pipe[gi-1]);
        end else if (gi == ST_N4) begin : g_n4
            assign n_pipe[gi] = st_n4(r_pipe[gi-1]);
        end else if (gi == ST_N1) begin : g_n1
            assign n_pipe[gi] = st_n1(r_pipe[gi-1]);
        end else begin : g_out
            assign n_pipe[gi] = st_out(r_pipe[gi-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NST; i++) begin
            if (w_adv[i]) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign w_res           = r_pipe[NST-1];
    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tuser  = w_res.wall;
    assign o_m_axis_tdata  = {3'b0, w_res.oor, w_res.secs, w_res.mins, w_res.hours,
                              w_res.day, w_res.month, w_res.year};

    a_uptime_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_res.wall |->
            w_res.year == BASE_YEAR && w_res.month == 4'd1 && w_res.day == 5'd1
            && !w_res.oor)
        else $error("uptime result carries calendar fields or range flag");

    a_oor_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.oor |->
            w_res.wall && w_res.hours == '0 && w_res.mins == '0 && w_res.secs == '0
            && w_res.year == BASE_YEAR)
        else $error("out of range result is not cleared");

    a_cal_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.wall && !w_res.oor |->
            w_res.month >= 4'd1 && w_res.month <= 4'd12 && w_res.day >= 5'd1
            && w_res.day <= 5'd31 && w_res.hours < 11'd24 && w_res.mins < 6'd60
            && w_res.secs < 6'd60 && w_res.year >= BASE_YEAR)
        else $error("calendar field out of bounds");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input refused although the output side is not blocked");

endmodule

`default_nettype wire
